// ----- design/ssma_pkg.sv -----
// ----------------------------------------------------------------------------
// ssma_pkg
// Shared widths, reset values and register map of the supervised moving
// average filter.
// ----------------------------------------------------------------------------
package ssma_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int LIMIT_W    = 4;
   localparam int WINDOW_DEF = 5;

   localparam logic [LIMIT_W-1:0] LIMIT_RST = 4'd5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from paddr above the byte offset
   localparam logic REG_FAILURE_LIMIT = 1'b0;

endpackage

// ----- design/sensor_supervised_moving_average.sv -----
// ----------------------------------------------------------------------------
// sensor_supervised_moving_average
// Sensor supervisor with a moving average over a row of sample cells.
// A request that publishes nothing goes from idle to the response; for a
//   published mean the partial sum runs down the cell row and then the
//   bit-serial divider works out the mean in SUM_W steps.
// A new request is taken only once the last response has been registered.
// Reset: not ready, no fault, empty window, failure limit 5.
// ----------------------------------------------------------------------------
module sensor_supervised_moving_average import ssma_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request: [0] init_ok, [16:1] sample, [23:17] zero
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,
   // request: [0] read_ok
   input  logic                  req_tuser,
   // response: [15:0] filtered_temp, [16] error_flag, [17] sensor_ready,
   //           [21:18] failure_count, [23:22] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,
   // response: [0] published
   output logic                  rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SUM  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      seq_ff, seq_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic [LIMIT_W-1:0]    fail_ff, fail_in;
   logic                  ready_ff, ready_in;
   logic                  fault_ff, fault_in;
   logic                  pub_ff, pub_in;
   logic [LIMIT_W-1:0]    limit_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [23:0]           rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic                  req_fire;
   logic                  init_ok;
   logic                  read_ok;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                  push;
   logic                  slot_free;
   logic                  div_start;
   logic                  div_done;
   logic signed [SAMPLE_W-1:0] mean;
   logic                  csr_write;

   logic signed [SAMPLE_W-1:0] sample_chain [WINDOW+1];
   logic signed [SUM_W-1:0]    sum_chain    [WINDOW+1];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign init_ok    = req_tdata[0];
   assign req_sample = req_tdata[SAMPLE_W:1];
   assign read_ok    = req_tuser;

   // supervisor decisions, all settled at the accepting edge
   always_comb begin
      fill_in  = fill_ff;
      fail_in  = fail_ff;
      ready_in = ready_ff;
      fault_in = fault_ff;
      pub_in   = pub_ff;
      push     = 1'b0;
      if (req_fire) begin
         pub_in = 1'b0;
         if (!ready_ff && !init_ok) begin
            fault_in = 1'b1;
         end else begin
            if (!ready_ff) begin
               ready_in = 1'b1;
               fill_in  = '0;
               fail_in  = '0;
            end
            if (read_ok) begin
               fail_in  = '0;
               fault_in = 1'b0;
               push     = 1'b1;
               pub_in   = 1'b1;
               if (fill_in != CNT_W'(WINDOW)) begin
                  fill_in = fill_in + CNT_W'(1);
               end
            end else begin
               fail_in = fail_in + LIMIT_W'(1);
               if (fail_in >= limit_ff) begin
                  fault_in = 1'b1;
                  ready_in = 1'b0;
                  fail_in  = '0;
               end
            end
         end
      end
   end

   assign sample_chain[0] = req_sample;
   assign sum_chain[0]    = '0;

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      ssma_cell #(
         .SUM_W (SUM_W)
      ) u_cell (
         .clock       (clock),
         .shift_en    (push),
         .take        (CNT_W'(i) < fill_ff),
         .sample_prev (sample_chain[i]),
         .sum_prev    (sum_chain[i]),
         .sample_out  (sample_chain[i+1]),
         .sum_out     (sum_chain[i+1])
      );
   end

   assign div_start = (state_ff == ST_SUM) && (seq_ff == CNT_W'(WINDOW));

   ssma_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_chain[WINDOW]),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (mean)
   );

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      seq_in       = seq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               seq_in   = '0;
               state_in = pub_in ? ST_SUM : ST_DONE;
            end
         end
         ST_SUM: begin
            seq_in = seq_ff + CNT_W'(1);
            if (div_start) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = pub_ff;
               rsp_data_in  = {2'b00, fail_ff, ready_ff, fault_ff,
                               pub_ff ? mean : SAMPLE_W'(0)};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seq_ff       <= '0;
         fill_ff      <= '0;
         fail_ff      <= '0;
         ready_ff     <= 1'b0;
         fault_ff     <= 1'b0;
         pub_ff       <= 1'b0;
         limit_ff     <= LIMIT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seq_ff       <= seq_in;
         fill_ff      <= fill_in;
         fail_ff      <= fail_in;
         ready_ff     <= ready_in;
         fault_ff     <= fault_in;
         pub_ff       <= pub_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && csr_paddr[CSR_ADDR_W-1] == REG_FAILURE_LIMIT) begin
            limit_ff <= csr_pwdata[LIMIT_W-1:0];
         end
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_FAILURE_LIMIT) ?
                       CSR_DATA_W'(limit_ff) : '0;

endmodule

// ----- design/ssma_cell.sv -----
// ----------------------------------------------------------------------------
// ssma_cell
// One tap of the sample line: holds one stored sample, shifts it to the next
// cell on a push and, if take is set, adds it to the partial sum down the row.
// ----------------------------------------------------------------------------
module ssma_cell import ssma_pkg::*; #(
   parameter int SUM_W = SAMPLE_W + 3
) (
   input  logic                       clock,
   input  logic                       shift_en,
   input  logic                       take,
   input  logic signed [SAMPLE_W-1:0] sample_prev,
   input  logic signed [SUM_W-1:0]    sum_prev,
   output logic signed [SAMPLE_W-1:0] sample_out,
   output logic signed [SUM_W-1:0]    sum_out
);

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SUM_W-1:0]    sum_in;

   assign sum_in = take ? sum_prev + SUM_W'(sample_ff) : sum_prev;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         sample_ff <= sample_prev;
      end
      sum_ff <= sum_in;
   end

   assign sample_out = sample_ff;
   assign sum_out    = sum_ff;

endmodule

// ----- design/ssma_div.sv -----
// ----------------------------------------------------------------------------
// ssma_div
// Signed by unsigned restoring divider, one quotient bit per cycle, quotient
// truncated toward zero.
// ----------------------------------------------------------------------------
module ssma_div import ssma_pkg::*; #(
   parameter int SUM_W = SAMPLE_W + 3,
   parameter int CNT_W = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SUM_W-1:0]    dividend,
   input  logic [CNT_W-1:0]           divisor,
   output logic                       done,
   output logic signed [SAMPLE_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;
   logic [SUM_W-1:0]  mag_ff, mag_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W:0]    shifted;
   logic [CNT_W:0]    diff;
   logic              fits;

   assign shifted = {rem_ff, mag_ff[SUM_W-1]};
   assign fits    = shifted >= {1'b0, divisor};
   assign diff    = shifted - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in  = dividend[SUM_W-1];
         mag_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_in  = '0;
      end else if (busy_ff) begin
         mag_in  = {mag_ff[SUM_W-2:0], fits};
         rem_in  = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? SAMPLE_W'(0) - mag_ff[SAMPLE_W-1:0] : mag_ff[SAMPLE_W-1:0];

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the supervised moving-average temperature filter. It starts
// with a table of requests: init failures and successes, window fill and
// wrap at sample extremes, failure counting up to a trip, and limit changes.
// Then random runs of good reads, failure bursts, failed inits and noise
// follow under several failure limits. Every response is checked field by
// field against the table's expected reading where its row gives one, else
// against an in-bench model of the supervisor and the averaging window. The
// response side stalls at random and once holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
   import ssma_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN             = WINDOW_DEF;
   localparam int ITEMS_PER_PHASE = 245;
   localparam int PHASES          = 6;
   localparam int HOLD_CYCLES     = 400;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int TAIL_CYCLES     = 40;

   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = {REG_FAILURE_LIMIT, 2'b00};

   typedef struct packed {
      logic [15:0] filtered_temp;
      logic        published;
      logic        error_flag;
      logic        sensor_ready;
      logic [3:0]  failure_count;
   } reading_type;

   typedef struct {
      logic       set_limit;
      logic [3:0] limit;
      logic       init_ok;
      logic       read_ok;
      logic [15:0] sample;
      logic       known;
      reading_type want;
   } step_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [23:0]           req_tdata;   // [0] init_ok, [16:1] sample, [23:17] zero
   logic                  req_tuser;   // [0] read_ok
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [23:0]           rsp_tdata;   // [15:0] filtered_temp, [16] error_flag,
                                       // [17] sensor_ready, [21:18] failure_count
   logic                  rsp_tuser;   // [0] published
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sensor_supervised_moving_average #(
      .WINDOW (WIN)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // model state
   logic signed [15:0] win_ring [WIN];
   int                 win_pos   = 0;
   int                 win_fill  = 0;
   logic [3:0]         fail_cnt  = '0;
   logic               is_ready  = 1'b0;
   logic               is_fault  = 1'b0;
   logic [3:0]         fail_limit = LIMIT_RST;

   reading_type  pending_readings [$];
   step_row_type step_table [$];
   int           mismatches    = 0;
   int           readings_seen = 0;

   // request-side flags shared with the monitor and the response side
   logic        cur_known = 1'b0;
   reading_type cur_want  = '0;
   bit          idle_on   = 1'b1;
   bit          hold_off_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic reading_type sensor_reading(logic [15:0] temp, logic pub, logic err,
                                                  logic rdy, logic [3:0] cnt);
      reading_type r;
      r.filtered_temp = temp;
      r.published     = pub;
      r.error_flag    = err;
      r.sensor_ready  = rdy;
      r.failure_count = cnt;
      return r;
   endfunction

   function automatic reading_type next_reading(logic init_ok, logic read_ok,
                                                logic signed [15:0] sample);
      reading_type r;
      logic        go;
      int          total;
      r  = '0;
      go = 1'b1;
      if (!is_ready) begin
         if (!init_ok) begin
            is_fault = 1'b1;
            go       = 1'b0;
         end else begin
            is_ready = 1'b1;
            win_pos  = 0;
            win_fill = 0;
            fail_cnt = '0;
         end
      end
      if (go) begin
         if (read_ok) begin
            fail_cnt = '0;
            is_fault = 1'b0;
            win_ring[win_pos] = sample;
            win_pos = (win_pos == WIN - 1) ? 0 : win_pos + 1;
            if (win_fill < WIN) win_fill++;
            total = 0;
            for (int i = 0; i < win_fill; i++) total += win_ring[i];
            r.filtered_temp = 16'(total / win_fill);
            r.published     = 1'b1;
         end else begin
            fail_cnt = fail_cnt + 4'd1;
            if (fail_cnt >= fail_limit) begin
               is_fault = 1'b1;
               is_ready = 1'b0;
               fail_cnt = '0;
            end
         end
      end
      r.error_flag    = is_fault;
      r.sensor_ready  = is_ready;
      r.failure_count = fail_cnt;
      return r;
   endfunction

   function automatic logic [15:0] pick_sample();
      logic [15:0] v;
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(3))
               0: v = 16'h7FFF;
               1: v = 16'h8000;
               2: v = 16'h0000;
               default: v = 16'hFFFF;
            endcase
         end
         1, 2, 3: begin
            v = 16'($urandom_range(16'h1FFF)) - 16'h1000;
         end
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("reading %0d: %s expected %h, got %h", readings_seen, what, want, got);
      end
   endtask

   // monitor: prediction on request accept, compare on response accept
   always @(posedge clock) begin : monitor
      reading_type got;
      reading_type want;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == REG_FAILURE_LIMIT)
            fail_limit = csr_pwdata[LIMIT_W-1:0];
         if (req_tvalid && req_tready) begin
            want = next_reading(req_tdata[0], req_tuser, req_tdata[16:1]);
            pending_readings.push_back(cur_known ? cur_want : want);
         end
         if (rsp_tvalid && rsp_tready) begin
            readings_seen++;
            got = sensor_reading(rsp_tdata[15:0], rsp_tuser, rsp_tdata[16], rsp_tdata[17],
                                 rsp_tdata[21:18]);
            if (pending_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("reading %0d: unexpected response %h", readings_seen, got);
            end else begin
               want = pending_readings.pop_front();
               check_field("filtered_temp", got.filtered_temp, want.filtered_temp);
               check_field("published", 16'(got.published), 16'(want.published));
               check_field("error_flag", 16'(got.error_flag), 16'(want.error_flag));
               check_field("sensor_ready", 16'(got.sensor_ready), 16'(want.sensor_ready));
               check_field("failure_count", 16'(got.failure_count),
                           16'(want.failure_count));
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset ||
          (csr_psel && csr_penable))
         quiet = 0;
      else
         quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response side
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_tready <= !(idle_on && $urandom_range(99) < 7);
         end
      end
   end

   task automatic send_request(logic init_ok, logic read_ok, logic [15:0] sample,
                               logic known, reading_type want);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      cur_known  = known;
      cur_want   = want;
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, sample, init_ok};
      req_tuser  <= read_ok;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
   endtask

   task automatic write_limit(logic [3:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LIMIT_ADDR;
      csr_pwdata  <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic add_row(logic set_limit, logic [3:0] limit, logic init_ok, logic read_ok,
                          logic [15:0] sample, logic known, reading_type want);
      step_row_type row;
      row.set_limit = set_limit;
      row.limit     = limit;
      row.init_ok   = init_ok;
      row.read_ok   = read_ok;
      row.sample    = sample;
      row.known     = known;
      row.want      = want;
      step_table.push_back(row);
   endtask

   // request side
   initial begin
      logic [3:0] phase_limit [PHASES];
      int         kind;
      int         run_len;
      int         sent;
      bit         held;
      bit         paused;
      logic       init_ok;
      logic       read_ok;
      logic [15:0] sample;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // failed init ignores the read
      add_row(0, 0, 0, 1, 16'h1234, 1, sensor_reading(16'h0000, 0, 1, 0, 4'd0));
      add_row(0, 0, 1, 1, 16'h7FFF, 1, sensor_reading(16'h7FFF, 1, 0, 1, 4'd0));
      // init result ignored while ready
      add_row(0, 0, 0, 1, 16'h7FFF, 1, sensor_reading(16'h7FFF, 1, 0, 1, 4'd0));
      // fill and wrap the window
      repeat (4) add_row(0, 0, 1, 1, 16'h8000, 0, '0);
      add_row(0, 0, 1, 0, 16'hFFFF, 1, sensor_reading(16'h0000, 0, 0, 1, 4'd1));
      add_row(0, 0, 1, 0, 16'hFFFF, 1, sensor_reading(16'h0000, 0, 0, 1, 4'd2));
      add_row(0, 0, 1, 0, 16'hFFFF, 1, sensor_reading(16'h0000, 0, 0, 1, 4'd3));
      add_row(0, 0, 1, 0, 16'hFFFF, 1, sensor_reading(16'h0000, 0, 0, 1, 4'd4));
      add_row(0, 0, 0, 0, 16'hFFFF, 1, sensor_reading(16'h0000, 0, 1, 0, 4'd0));
      // init succeeds, error stays set until a good read
      add_row(0, 0, 1, 0, 16'h0000, 1, sensor_reading(16'h0000, 0, 1, 1, 4'd1));
      add_row(0, 0, 1, 1, 16'hFFFF, 1, sensor_reading(16'hFFFF, 1, 0, 1, 4'd0));
      // -1/2 truncates toward zero
      add_row(0, 0, 1, 1, 16'h0000, 1, sensor_reading(16'h0000, 1, 0, 1, 4'd0));
      add_row(0, 0, 1, 0, 16'h0000, 1, sensor_reading(16'h0000, 0, 0, 1, 4'd1));
      add_row(0, 0, 1, 0, 16'h0000, 1, sensor_reading(16'h0000, 0, 0, 1, 4'd2));
      // limit lowered below the count
      add_row(1, 4'd1, 1, 0, 16'h0000, 1, sensor_reading(16'h0000, 0, 1, 0, 4'd0));
      // limit of zero trips on the first failed read
      add_row(1, 4'd0, 1, 0, 16'h0000, 1, sensor_reading(16'h0000, 0, 1, 0, 4'd0));
      add_row(1, 4'd15, 1, 1, 16'h0100, 1, sensor_reading(16'h0100, 1, 0, 1, 4'd0));
      add_row(0, 0, 1, 1, 16'h8001, 0, '0);

      foreach (step_table[i]) begin
         if (step_table[i].set_limit) begin
            drain();
            write_limit(step_table[i].limit);
         end
         send_request(step_table[i].init_ok, step_table[i].read_ok, step_table[i].sample,
                      step_table[i].known, step_table[i].want);
      end

      phase_limit[0] = 4'd15;
      phase_limit[1] = 4'd1;
      phase_limit[2] = 4'd0;
      phase_limit[3] = 4'd3;
      phase_limit[4] = 4'($urandom_range(1, 15));
      phase_limit[5] = LIMIT_RST;
      held   = 1'b0;
      paused = 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_limit(phase_limit[p]);
         idle_on = (p != 3);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if (p == 1 && sent >= 100 && !held) begin
               held = 1'b1;
               hold_off_req = 1'b1;
            end
            if (p == 2 && sent >= 120 && !paused) begin
               paused = 1'b1;
               drain();
            end
            kind = $urandom_range(9);
            case (kind)
               6, 7: run_len = $urandom_range(1, 17);
               8: run_len = $urandom_range(1, 3);
               9: run_len = $urandom_range(1, 6);
               default: run_len = $urandom_range(1, 12);
            endcase
            for (int k = 0; k < run_len; k++) begin
               case (kind)
                  6, 7: begin
                     init_ok = 1'b1;
                     read_ok = 1'b0;
                     sample  = 16'($urandom);
                  end
                  8: begin
                     init_ok = 1'b0;
                     read_ok = 1'($urandom);
                     sample  = 16'($urandom);
                  end
                  9: begin
                     init_ok = 1'($urandom);
                     read_ok = 1'($urandom);
                     sample  = 16'($urandom);
                  end
                  default: begin
                     init_ok = ($urandom_range(9) != 0);
                     read_ok = ($urandom_range(9) != 0);
                     sample  = pick_sample();
                  end
               endcase
               send_request(init_ok, read_ok, sample, 1'b0, '0);
               sent++;
            end
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_readings.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
